// ----- design/pess_pkg.sv -----
// Shared types and constants for the periodic event slot scheduler.
`default_nettype none

package pess_pkg;

  localparam int MAX_SLOTS          = 16;
  localparam int SLOT_W             = 4;
  localparam int PROC_SLOTS_DEFAULT = 16;
  localparam int IRQ_SLOTS_DEFAULT  = 16;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_REG   = 2'd1;
  localparam logic [1:0] KIND_UNREG = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_REG,
    OP_UNREG,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    op_t         op;
    logic        irq;
    logic [15:0] tag;
    logic [15:0] period;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [MAX_SLOTS-1:0] mask;
  } res_t;

endpackage

`default_nettype wire

// ----- design/pess_fifo.sv -----
// Two-entry queue used between the scheduler stages.
`default_nettype none

module pess_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [0:1];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/pess_front.sv -----
// Front end: accepts input transactions, decodes the kind and queues commands.
`default_nettype none

module pess_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire logic [1:0]     kind,
  input  wire logic           table_select,
  input  wire logic [15:0]    handler_tag,
  input  wire logic [15:0]    period_ticks,
  output pess_pkg::cmd_t      cmd,
  output logic                cmd_valid,
  input  wire logic           cmd_pop
);
  import pess_pkg::*;

  cmd_t                 cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_q;
  logic                 cmd_empty;

  always_comb begin
    cmd_in.irq    = table_select;
    cmd_in.tag    = handler_tag;
    cmd_in.period = period_ticks;
    unique case (kind)
      KIND_TICK:  cmd_in.op = OP_TICK;
      KIND_REG:   cmd_in.op = OP_REG;
      KIND_UNREG: cmd_in.op = OP_UNREG;
      default:    cmd_in.op = OP_NOP;
    endcase
  end

  pess_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_q),
    .full    (full),
    .empty   (cmd_empty)
  );

  assign cmd       = cmd_t'(cmd_q);
  assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// ----- design/pess_back.sv -----
// Back end: slot tables and the sequencer that walks them one slot per cycle.
`default_nettype none

module pess_back #(
  parameter int PROC_SLOTS = pess_pkg::PROC_SLOTS_DEFAULT,
  parameter int IRQ_SLOTS  = pess_pkg::IRQ_SLOTS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire pess_pkg::cmd_t cmd,
  input  wire logic       cmd_valid,
  output logic            cmd_pop,
  output pess_pkg::res_t  res,
  output logic            res_push,
  input  wire logic       res_full
);
  import pess_pkg::*;

  localparam logic [SLOT_W-1:0] PROC_LAST = SLOT_W'(PROC_SLOTS - 1);
  localparam logic [SLOT_W-1:0] IRQ_LAST  = SLOT_W'(IRQ_SLOTS - 1);

  logic [15:0] tag_mem [0:1][0:MAX_SLOTS-1];
  logic [15:0] per_mem [0:1][0:MAX_SLOTS-1];
  logic [15:0] cnt_mem [0:1][0:MAX_SLOTS-1];

  bk_state_t         state;
  bk_state_t         state_next;
  cmd_t              cur;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] last_idx;
  res_t              acc;

  logic [15:0] rd_tag;
  logic [15:0] rd_per;
  logic [15:0] rd_cnt;
  logic [16:0] cnt_inc;
  logic        fire;
  logic        occupied;
  logic        hit;
  logic        at_last;
  logic        walk;
  logic        tick_upd;

  assign rd_tag   = tag_mem[cur.irq][idx];
  assign rd_per   = per_mem[cur.irq][idx];
  assign rd_cnt   = cnt_mem[cur.irq][idx];
  assign cnt_inc  = {1'b0, rd_cnt} + 17'd1;
  assign fire     = (cnt_inc >= {1'b0, rd_per});
  assign occupied = (rd_tag != 16'd0);
  assign last_idx = cur.irq ? IRQ_LAST : PROC_LAST;
  assign at_last  = (idx == last_idx);
  assign hit      = ((cur.op == OP_REG) && !occupied) ||
                    ((cur.op == OP_UNREG) && (rd_tag == cur.tag));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.op == OP_NOP) ? BK_DONE : BK_WALK;
        end
      end
      BK_WALK: begin
        if (hit || at_last) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!res_full) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    walk     = 1'b0;
    unique case (state)
      BK_IDLE: cmd_pop  = cmd_valid;
      BK_WALK: walk     = 1'b1;
      BK_DONE: res_push = !res_full;
      default: ;
    endcase
  end

  assign tick_upd = walk && (cur.op == OP_TICK) && occupied;
  assign res      = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command and result registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur        <= cmd;
      idx        <= '0;
      acc.status <= ST_OK;
      acc.slot   <= '0;
      acc.mask   <= '0;
    end else if (walk) begin
      idx <= idx + SLOT_W'(1);
      if (tick_upd && fire) begin
        acc.mask[idx] <= 1'b1;
      end
      if (hit) begin
        acc.slot <= idx;
      end else if (at_last) begin
        if (cur.op == OP_REG) begin
          acc.status <= ST_FULL;
        end else if (cur.op == OP_UNREG) begin
          acc.status <= ST_NOT_FOUND;
        end
      end
    end
  end

  // Slot tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < 2; t++) begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
          tag_mem[t][s] <= '0;
          per_mem[t][s] <= '0;
          cnt_mem[t][s] <= '0;
        end
      end
    end else if (tick_upd) begin
      cnt_mem[cur.irq][idx] <= fire ? 16'd0 : cnt_inc[15:0];
    end else if (walk && hit) begin
      if (cur.op == OP_REG) begin
        tag_mem[cur.irq][idx] <= cur.tag;
        per_mem[cur.irq][idx] <= cur.period;
      end else begin
        tag_mem[cur.irq][idx] <= '0;
        per_mem[cur.irq][idx] <= '0;
      end
      cnt_mem[cur.irq][idx] <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- design/periodic_event_slot_scheduler.sv -----
// Top level of the periodic event slot scheduler: front end, slot engine, result queue.
// A tick walks every slot of the selected table, then queues its result.
// The engine handles one transaction at a time and walks one slot a cycle;
//   register stops at the first free slot, unregister at the first tag match; an unused kind walks none.
// Reset (rst, synchronous, high): both slot tables cleared to empty, queues emptied.
// Inputs are taken while the engine works, up to two queued ahead and two results waiting.
`default_nettype none

module periodic_event_slot_scheduler #(
  parameter int PROC_SLOTS = pess_pkg::PROC_SLOTS_DEFAULT,
  parameter int IRQ_SLOTS  = pess_pkg::IRQ_SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input transaction queue side
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  kind,
  input  wire logic        table_select,
  input  wire logic [15:0] handler_tag,
  input  wire logic [15:0] period_ticks,
  // result transaction queue side
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status,
  output logic [3:0]       slot_index,
  output logic [15:0]      fire_mask
);
  import pess_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;
  logic [$bits(res_t)-1:0] res_q;

  // Front end decodes each transaction's kind and buffers it.
  pess_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .table_select (table_select),
    .handler_tag  (handler_tag),
    .period_ticks (period_ticks),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop)
  );

  // Slot engine: one slot per cycle through the selected table.
  pess_back #(
    .PROC_SLOTS (PROC_SLOTS),
    .IRQ_SLOTS  (IRQ_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res       (res_in),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // Result queue decouples the engine from the consumer.
  pess_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_q),
    .full    (res_full),
    .empty   (empty)
  );

  assign res_out    = res_t'(res_q);
  assign status     = res_out.status;
  assign slot_index = res_out.slot;
  assign fire_mask  = res_out.mask;

endmodule

`default_nettype wire
